[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[sv/alps_pkg.sv]
// ----------------------------------------------------------------------------
// alps_pkg
// Shared types, register map and saturation helpers for the motion step.
// ----------------------------------------------------------------------------
`default_nettype none

package alps_pkg;

  // register map, index = byte address / 4
  localparam logic [2:0] REG_ACCEL = 3'd0;
  localparam logic [2:0] REG_SPEED = 3'd1;
  localparam logic [2:0] REG_LOWER = 3'd2;
  localparam logic [2:0] REG_UPPER = 3'd3;
  localparam logic [2:0] REG_WRAP  = 3'd4;

  localparam logic [30:0]        ACCEL_RST = 31'd65536;
  localparam logic [30:0]        SPEED_RST = 31'd655360;
  localparam logic signed [31:0] LOWER_RST = 32'shC000_0000;
  localparam logic signed [31:0] UPPER_RST = 32'sh3FFF_FFFF;

  localparam int SQRT_STEPS = 32;

  typedef struct packed {
    logic [30:0]        accel;
    logic [30:0]        vmax;
    logic signed [31:0] lower;
    logic signed [31:0] upper;
    logic               wrap;
  } cfg_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ERR,
    S_WRAP,
    S_DIFF,
    S_CMP,
    S_MULV,
    S_MULA,
    S_PROD,
    S_BCMP,
    S_SQRT,
    S_SIGN,
    S_DV,
    S_CLAMP,
    S_NV,
    S_NP,
    S_PWRAP,
    S_FIN
  } state_t;

  function automatic logic signed [33:0] sat34(input logic signed [35:0] x);
    logic signed [33:0] r;
    if ((x[35:33] == 3'b000) || (x[35:33] == 3'b111)) begin
      r = x[33:0];
    end else if (x[35]) begin
      r = {1'b1, 33'd0};
    end else begin
      r = {1'b0, {33{1'b1}}};
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
    logic signed [31:0] r;
    if ((x[33:31] == 3'b000) || (x[33:31] == 3'b111)) begin
      r = x[31:0];
    end else if (x[33]) begin
      r = {1'b1, 31'd0};
    end else begin
      r = {1'b0, {31{1'b1}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/alps_regs.sv]
// ----------------------------------------------------------------------------
// alps_regs
// APB register file holding the motion limits, bounds and wrap mode.
// ----------------------------------------------------------------------------
`default_nettype none

module alps_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output alps_pkg::cfg_t      cfg
);

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.accel <= alps_pkg::ACCEL_RST;
      cfg.vmax  <= alps_pkg::SPEED_RST;
      cfg.lower <= alps_pkg::LOWER_RST;
      cfg.upper <= alps_pkg::UPPER_RST;
      cfg.wrap  <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        alps_pkg::REG_ACCEL: cfg.accel <= pwdata[30:0];
        alps_pkg::REG_SPEED: cfg.vmax  <= pwdata[30:0];
        alps_pkg::REG_LOWER: cfg.lower <= pwdata;
        alps_pkg::REG_UPPER: cfg.upper <= pwdata;
        alps_pkg::REG_WRAP:  cfg.wrap  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      alps_pkg::REG_ACCEL: prdata = {1'b0, cfg.accel};
      alps_pkg::REG_SPEED: prdata = {1'b0, cfg.vmax};
      alps_pkg::REG_LOWER: prdata = cfg.lower;
      alps_pkg::REG_UPPER: prdata = cfg.upper;
      alps_pkg::REG_WRAP:  prdata = {31'd0, cfg.wrap};
      default:             prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

[sv/accel_limited_position_step.sv]
// ----------------------------------------------------------------------------
// accel_limited_position_step
// One motion tick per input beat: steer position and velocity toward the
// target under acceleration and speed limits, with optional circular wrap.
// ----------------------------------------------------------------------------
//   channel   signals                             role
//   input     in_valid/in_ready, target_position  one tick per beat
//   output    out_valid/out_ready, step_position, one result per tick
//             step_velocity, arrived
//   config    psel/penable/pwrite/paddr/pwdata,   APB, 5 regs at 4*i
//             prdata/pready
//
// A tick that snaps to the target skips the multiply and square-root steps,
// one that saturates at the speed limit skips the square root, and one
// that needs the braking speed runs the 32-step shared-datapath square root.
// Reset is synchronous, clears position and velocity, presets the registers.
// in_ready is high only while the sequencer idles; a full output register
// holds the sequencer in its last step until the result beat is taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module accel_limited_position_step (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] target_position,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] step_position,
  output logic signed [31:0] step_velocity,
  output logic               arrived,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  alps_pkg::cfg_t   cfg;
  alps_pkg::state_t state, state_next;

  // architectural state
  logic signed [31:0] position, velocity;

  // per-tick working registers
  logic signed [31:0] tgt;
  logic signed [33:0] err;
  logic signed [32:0] range;
  logic signed [34:0] diff;
  logic [33:0]        mag;
  logic [30:0]        step_lim;
  logic               snap;
  logic [63:0]        mul_p, vsq, prod;
  logic [63:0]        sq_x, sq_res, sq_bit;
  logic [4:0]         sq_cnt;
  logic [31:0]        spd;
  logic signed [31:0] spd_s;
  logic signed [33:0] dv, nv, half, np;

  // shared multiplier operands
  logic [31:0] mul_a, mul_b;

  // combinational datapath terms
  logic signed [34:0] e2x, r35;
  logic               wrap_gt, wrap_lt, far;
  logic signed [35:0] wrap_sum, np_sum, pw_sum;
  logic signed [34:0] lim35;
  logic [32:0]        hi_term;
  logic [63:0]        b_val, sq_t, sq_res_next;
  logic               sq_take, b_small, commit, below;
  logic signed [33:0] acc34, fin_src;
  logic signed [31:0] fin_pos;

  alps_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign commit = !out_valid || out_ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      alps_pkg::S_IDLE:  if (in_valid) state_next = alps_pkg::S_ERR;
      alps_pkg::S_ERR:   state_next = alps_pkg::S_WRAP;
      alps_pkg::S_WRAP:  state_next = alps_pkg::S_DIFF;
      alps_pkg::S_DIFF:  state_next = alps_pkg::S_CMP;
      alps_pkg::S_CMP:   state_next = far ? alps_pkg::S_MULV : alps_pkg::S_FIN;
      alps_pkg::S_MULV:  state_next = alps_pkg::S_MULA;
      alps_pkg::S_MULA:  state_next = alps_pkg::S_PROD;
      alps_pkg::S_PROD:  state_next = alps_pkg::S_BCMP;
      alps_pkg::S_BCMP:  state_next = b_small ? alps_pkg::S_SQRT : alps_pkg::S_SIGN;
      alps_pkg::S_SQRT:  if (sq_cnt == 5'd0) state_next = alps_pkg::S_SIGN;
      alps_pkg::S_SIGN:  state_next = alps_pkg::S_DV;
      alps_pkg::S_DV:    state_next = alps_pkg::S_CLAMP;
      alps_pkg::S_CLAMP: state_next = alps_pkg::S_NV;
      alps_pkg::S_NV:    state_next = alps_pkg::S_NP;
      alps_pkg::S_NP:    state_next = alps_pkg::S_PWRAP;
      alps_pkg::S_PWRAP: state_next = alps_pkg::S_FIN;
      alps_pkg::S_FIN:   if (commit) state_next = alps_pkg::S_IDLE;
      default:           state_next = alps_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready = (state == alps_pkg::S_IDLE);
    unique case (state)
      alps_pkg::S_MULV: begin
        mul_a = {1'b0, cfg.vmax};
        mul_b = {1'b0, cfg.vmax};
      end
      alps_pkg::S_MULA: begin
        mul_a = mag[31:0];
        mul_b = {1'b0, cfg.accel};
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  // datapath terms
  always_comb begin
    e2x      = {err, 1'b0};
    r35      = {{2{range[32]}}, range};
    wrap_gt  = e2x > r35;
    wrap_lt  = e2x < -r35;
    wrap_sum = {{2{err[33]}}, err}
             + (wrap_gt ? -{{3{range[32]}}, range} : {{3{range[32]}}, range});

    lim35 = $signed({4'd0, step_lim});
    far   = (diff > lim35) || (diff < -lim35);

    case (mag[33:32])
      2'b00:   hi_term = 33'd0;
      2'b01:   hi_term = {2'd0, cfg.accel};
      2'b10:   hi_term = {1'b0, cfg.accel, 1'b0};
      default: hi_term = {2'd0, cfg.accel} + {1'b0, cfg.accel, 1'b0};
    endcase

    b_val   = {prod[62:0], 1'b0};
    b_small = (prod[63:62] == 2'b00) && (b_val < vsq);

    // one digit of the restoring square root
    sq_t        = sq_res + sq_bit;
    sq_take     = sq_x >= sq_t;
    sq_res_next = sq_take ? ((sq_res >> 1) + sq_bit) : (sq_res >> 1);

    acc34 = $signed({3'd0, cfg.accel});

    np_sum = {{2{half[33]}}, half} + {{2{nv[33]}}, nv} + {{4{position[31]}}, position};

    below  = np < $signed({{2{cfg.lower[31]}}, cfg.lower});
    pw_sum = {{2{np[33]}}, np}
           + (below ? {{3{range[32]}}, range} : -{{3{range[32]}}, range});

    fin_src = snap ? {{2{tgt[31]}}, tgt} : np;
    if (fin_src < $signed({{2{cfg.lower[31]}}, cfg.lower})) begin
      fin_pos = cfg.lower;
    end else if (fin_src > $signed({{2{cfg.upper[31]}}, cfg.upper})) begin
      fin_pos = cfg.upper;
    end else begin
      fin_pos = fin_src[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= alps_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
    case (state)
      alps_pkg::S_IDLE: begin
        tgt <= target_position;
      end
      alps_pkg::S_ERR: begin
        err   <= {{2{tgt[31]}}, tgt} - {{2{position[31]}}, position};
        range <= {cfg.upper[31], cfg.upper} - {cfg.lower[31], cfg.lower};
      end
      alps_pkg::S_WRAP: begin
        if (cfg.wrap && (wrap_gt || wrap_lt)) begin
          err <= alps_pkg::sat34(wrap_sum);
        end
      end
      alps_pkg::S_DIFF: begin
        diff     <= {err[33], err} - {{3{velocity[31]}}, velocity};
        mag      <= err[33] ? 34'(-err) : 34'(err);
        step_lim <= (cfg.accel <= cfg.vmax) ? cfg.accel : cfg.vmax;
      end
      alps_pkg::S_CMP: begin
        snap <= !far;
      end
      alps_pkg::S_MULA: begin
        vsq <= mul_p;
      end
      alps_pkg::S_PROD: begin
        prod <= mul_p + {hi_term[31:0], 32'd0};
      end
      alps_pkg::S_BCMP: begin
        sq_x   <= b_val;
        sq_res <= 64'd0;
        sq_bit <= 64'd1 << 62;
        sq_cnt <= 5'(alps_pkg::SQRT_STEPS - 1);
        spd    <= {1'b0, cfg.vmax};
      end
      alps_pkg::S_SQRT: begin
        if (sq_take) begin
          sq_x <= sq_x - sq_t;
        end
        sq_res <= sq_res_next;
        sq_bit <= sq_bit >> 2;
        sq_cnt <= sq_cnt - 5'd1;
        if (sq_cnt == 5'd0) begin
          spd <= sq_res_next[31:0];
        end
      end
      alps_pkg::S_SIGN: begin
        spd_s <= err[33] ? -$signed(spd) : $signed(spd);
      end
      alps_pkg::S_DV: begin
        dv <= {{2{spd_s[31]}}, spd_s} - {{2{velocity[31]}}, velocity};
      end
      alps_pkg::S_CLAMP: begin
        if (dv > acc34) begin
          dv <= acc34;
        end else if (dv < -acc34) begin
          dv <= -acc34;
        end
      end
      alps_pkg::S_NV: begin
        nv   <= {{2{velocity[31]}}, velocity} + dv;
        half <= dv >>> 1;
      end
      alps_pkg::S_NP: begin
        np <= alps_pkg::sat34(np_sum);
      end
      alps_pkg::S_PWRAP: begin
        if (cfg.wrap && (below || (np > $signed({{2{cfg.upper[31]}}, cfg.upper})))) begin
          np <= alps_pkg::sat34(pw_sum);
        end
      end
      default: ;
    endcase
  end

  // motion state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      position  <= 32'sd0;
      velocity  <= 32'sd0;
      out_valid <= 1'b0;
    end else begin
      if ((state == alps_pkg::S_FIN) && commit) begin
        position  <= fin_pos;
        velocity  <= snap ? 32'sd0 : alps_pkg::sat32(nv);
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == alps_pkg::S_FIN) && commit) begin
      step_position <= fin_pos;
      step_velocity <= snap ? 32'sd0 : alps_pkg::sat32(nv);
      arrived       <= snap;
    end
  end

  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  `ASSERT_IMPLY(a_arrive_zero_vel, clk, rst, out_valid && arrived, step_velocity == 32'sd0)
  `ASSERT_IMPLY(a_root_in_range, clk, rst, state == alps_pkg::S_SIGN, !spd[31])
  `ASSERT_NEXT(a_root_done, clk, rst, (state == alps_pkg::S_SQRT) && (sq_cnt == 5'd0), state == alps_pkg::S_SIGN)

endmodule

`default_nettype wire

[tb/accel_limited_position_step_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_limited_position_step_test
// Drives motion ticks through the valid/ready input, reprograms the limits
// and bounds over APB between phases, and checks each result beat against a
// cycle-free position/velocity model or against a fixed beat in the plan.
// ----------------------------------------------------------------------------

module accel_limited_position_step_test;

  localparam int TICK_TOTAL = 1850;
  localparam int PHASE_TICKS = 150;
  localparam int HOLD_CYCLES = 400;
  localparam longint TOP34 = 64'sd8589934591;
  localparam longint BOT34 = -64'sd8589934592;
  localparam longint TOP32 = 64'sd2147483647;
  localparam longint BOT32 = -64'sd2147483648;
  localparam bit ROW_TICK = 1'b0;
  localparam bit ROW_REG = 1'b1;

  typedef struct packed {
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic               arr;
  } motion_t;

  typedef struct packed {
    bit          kind;
    logic [2:0]  idx;
    logic [31:0] val;
    bit          fixed;
    motion_t     want;
  } plan_row_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] target_position;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] step_position;
  logic signed [31:0] step_velocity;
  logic               arrived;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [4:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  // tracked block state and register copies
  longint      track_pos;
  longint      track_vel;
  longint      cfg_lo;
  longint      cfg_hi;
  logic [30:0] cfg_accel;
  logic [30:0] cfg_vmax;
  bit          cfg_wrap;

  motion_t due_results[$];
  int      mismatches = 0;
  int      ticks_sent = 0;
  int      idle_pct = 0;
  int      stall_pct = 0;
  int      hold_seq = 0;
  int      hold_seen = 0;
  int      hold_left = 0;

  plan_row_t plan [0:32] = '{
    '{ROW_TICK, '0, 32'h0000_0000, 1'b1, '{32'h0000_0000, 32'h0, 1'b1}},
    '{ROW_TICK, '0, 32'h0000_8000, 1'b1, '{32'h0000_8000, 32'h0, 1'b1}},
    '{ROW_TICK, '0, 32'h8000_0000, 1'b0, '0},
    '{ROW_TICK, '0, 32'h7FFF_FFFF, 1'b0, '0},
    '{ROW_TICK, '0, 32'h7FFF_FFFF, 1'b0, '0},
    '{ROW_REG, alps_pkg::REG_ACCEL, 32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_REG, alps_pkg::REG_SPEED, 32'h7FFF_FFFF, 1'b0, '0},
    '{ROW_TICK, '0, 32'h0000_0000, 1'b1, '{32'h0000_0000, 32'h0, 1'b1}},
    // snap lands past the upper bound
    '{ROW_TICK, '0, 32'h7FFF_FFFF, 1'b1, '{32'h3FFF_FFFF, 32'h0, 1'b1}},
    // braking product too large, run at the speed limit
    '{ROW_TICK, '0, 32'h8000_0000, 1'b0, '0},
    '{ROW_TICK, '0, 32'hC000_0000, 1'b1, '{32'hC000_0000, 32'h0, 1'b1}},
    '{ROW_REG, alps_pkg::REG_ACCEL, 32'h0000_0000, 1'b0, '0},
    '{ROW_TICK, '0, 32'hC000_0000, 1'b1, '{32'hC000_0000, 32'h0, 1'b1}},
    '{ROW_TICK, '0, 32'h4000_0000, 1'b1, '{32'hC000_0000, 32'h0, 1'b0}},
    '{ROW_REG, alps_pkg::REG_ACCEL, 32'h0001_0000, 1'b0, '0},
    '{ROW_REG, alps_pkg::REG_SPEED, 32'h0000_0000, 1'b0, '0},
    '{ROW_TICK, '0, 32'h0100_0000, 1'b0, '0},
    '{ROW_TICK, '0, 32'h0100_0000, 1'b0, '0},
    // inverted bounds with wrap on
    '{ROW_REG, alps_pkg::REG_LOWER, 32'h1000_0000, 1'b0, '0},
    '{ROW_REG, alps_pkg::REG_UPPER, 32'hF000_0000, 1'b0, '0},
    '{ROW_REG, alps_pkg::REG_WRAP, 32'h0000_0001, 1'b0, '0},
    '{ROW_TICK, '0, 32'h0000_0000, 1'b0, '0},
    '{ROW_TICK, '0, 32'h7000_0000, 1'b0, '0},
    '{ROW_REG, alps_pkg::REG_SPEED, 32'h0008_0000, 1'b0, '0},
    '{ROW_REG, alps_pkg::REG_LOWER, 32'hFFF0_0000, 1'b0, '0},
    '{ROW_REG, alps_pkg::REG_UPPER, 32'h0010_0000, 1'b0, '0},
    '{ROW_TICK, '0, 32'h000F_0000, 1'b0, '0},
    '{ROW_TICK, '0, 32'hFFF1_0000, 1'b0, '0},
    '{ROW_TICK, '0, 32'hFFF1_0000, 1'b0, '0},
    '{ROW_TICK, '0, 32'h0000_4000, 1'b0, '0},
    '{ROW_REG, alps_pkg::REG_WRAP, 32'hFFFF_FFFE, 1'b0, '0},
    '{ROW_TICK, '0, 32'h7FFF_FFFF, 1'b0, '0},
    '{ROW_TICK, '0, 32'h8000_0000, 1'b0, '0}
  };

  accel_limited_position_step dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .target_position (target_position),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .step_position   (step_position),
    .step_velocity   (step_velocity),
    .arrived         (arrived),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint clip34(input longint x);
    if (x > TOP34) return TOP34;
    if (x < BOT34) return BOT34;
    return x;
  endfunction

  function automatic longint clip32(input longint x);
    if (x > TOP32) return TOP32;
    if (x < BOT32) return BOT32;
    return x;
  endfunction

  function automatic longint keep_in_bounds(input longint x);
    if (x < cfg_lo) return cfg_lo;
    if (x > cfg_hi) return cfg_hi;
    return x;
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned probe;
    root = 0;
    probe = 64'd1 << 62;
    while (probe > v) probe >>= 2;
    while (probe != 0) begin
      if (v >= root + probe) begin
        v -= root + probe;
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  // one motion tick: update the tracked state and return the result beat
  function automatic motion_t advance_motion(input logic signed [31:0] tgt);
    longint t, rng, acc, vmax, err, lim, gap, spd, dv, nv, np;
    longint unsigned mag, prod, vsq, b;
    motion_t r;
    t = tgt;
    rng = cfg_hi - cfg_lo;
    acc = longint'(cfg_accel);
    vmax = longint'(cfg_vmax);
    err = clip34(t - track_pos);
    lim = (acc <= vmax) ? acc : vmax;
    if (cfg_wrap) begin
      if (2 * err > rng) err = clip34(err - rng);
      else if (2 * err < -rng) err = clip34(err + rng);
    end
    gap = err - track_vel;
    if (gap < 0) gap = -gap;
    if (gap > lim) begin
      mag = (err < 0) ? -err : err;
      prod = mag * {33'd0, cfg_accel};
      vsq = {33'd0, cfg_vmax} * {33'd0, cfg_vmax};
      spd = vmax;
      if (prod < (64'd1 << 62)) begin
        b = prod << 1;
        if (b < vsq) spd = longint'(floor_sqrt(b));
      end
      if (err < 0) spd = -spd;
      dv = spd - track_vel;
      if (dv > acc) dv = acc;
      else if (dv < -acc) dv = -acc;
      nv = track_vel + dv;
      np = clip34((dv >>> 1) + nv + track_pos);
      if (cfg_wrap) begin
        if (np < cfg_lo) np = clip34(np + rng);
        else if (np > cfg_hi) np = clip34(np - rng);
      end
      track_pos = keep_in_bounds(np);
      track_vel = clip32(nv);
      r.arr = 1'b0;
    end else begin
      track_pos = keep_in_bounds(t);
      track_vel = 0;
      r.arr = 1'b1;
    end
    r.pos = track_pos[31:0];
    r.vel = track_vel[31:0];
    return r;
  endfunction

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);
  endtask

  task automatic offer_target(input logic signed [31:0] tgt, input bit fixed,
                              input motion_t fix);
    motion_t want;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    target_position <= tgt;
    do @(posedge clk); while (!in_ready);
    want = advance_motion(tgt);
    due_results.push_back(fixed ? fix : want);
    ticks_sent++;
  endtask

  // write over APB once the block is idle, then read the register back
  task automatic set_register(input logic [2:0] idx, input logic [31:0] val);
    logic [31:0] held;
    drain_results();
    case (idx)
      alps_pkg::REG_ACCEL: begin
        cfg_accel = val[30:0];
        held = {1'b0, val[30:0]};
      end
      alps_pkg::REG_SPEED: begin
        cfg_vmax = val[30:0];
        held = {1'b0, val[30:0]};
      end
      alps_pkg::REG_LOWER: begin
        cfg_lo = longint'($signed(val));
        held = val;
      end
      alps_pkg::REG_UPPER: begin
        cfg_hi = longint'($signed(val));
        held = val;
      end
      alps_pkg::REG_WRAP: begin
        cfg_wrap = val[0];
        held = {31'd0, val[0]};
      end
      default: held = '0;
    endcase
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== held) begin
      $display("%0t: register %0d read expected %h got %h", $time, idx, held, prdata);
      mismatches++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // result side: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    motion_t want;
    if (!rst && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result beat pos %h vel %h arrived %b", $time,
                 step_position, step_velocity, arrived);
        mismatches++;
      end else begin
        want = due_results.pop_front();
        if (step_position !== want.pos) begin
          $display("%0t: step_position expected %h got %h", $time, want.pos, step_position);
          mismatches++;
        end
        if (step_velocity !== want.vel) begin
          $display("%0t: step_velocity expected %h got %h", $time, want.vel, step_velocity);
          mismatches++;
        end
        if (arrived !== want.arr) begin
          $display("%0t: arrived expected %b got %b", $time, want.arr, arrived);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #12_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int phase;
    int phase_stop;
    int reps;
    logic [31:0] acc_w, spd_w, lo_w, hi_w, span;
    logic signed [31:0] goal, offs;
    rst = 1'b1;
    in_valid = 1'b0;
    target_position = '0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    track_pos = 0;
    track_vel = 0;
    cfg_accel = alps_pkg::ACCEL_RST;
    cfg_vmax = alps_pkg::SPEED_RST;
    cfg_lo = alps_pkg::LOWER_RST;
    cfg_hi = alps_pkg::UPPER_RST;
    cfg_wrap = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i <= 32; i++) begin
      if (plan[i].kind == ROW_REG) set_register(plan[i].idx, plan[i].val);
      else offer_target(plan[i].val, plan[i].fixed, plan[i].want);
    end

    phase = 0;
    while (ticks_sent < TICK_TOTAL) begin
      case ($urandom_range(7))
        0: acc_w = '0;
        1: acc_w = 32'hFFFF_FFFF;
        2: acc_w = $urandom;
        default: acc_w = $urandom_range(32'h0004_0000, 1);
      endcase
      case ($urandom_range(7))
        0: spd_w = '0;
        1: spd_w = 32'h7FFF_FFFF;
        2: spd_w = $urandom;
        default: spd_w = $urandom_range(32'h0100_0000, 1);
      endcase
      case ($urandom_range(5))
        0: begin
          lo_w = 32'h8000_0000;
          hi_w = 32'h7FFF_FFFF;
        end
        1: begin
          lo_w = $urandom;
          hi_w = $urandom;
        end
        default: begin
          lo_w = $urandom;
          span = $urandom >> $urandom_range(28, 4);
          hi_w = lo_w + span;
        end
      endcase
      set_register(alps_pkg::REG_ACCEL, acc_w);
      set_register(alps_pkg::REG_SPEED, spd_w);
      set_register(alps_pkg::REG_LOWER, lo_w);
      set_register(alps_pkg::REG_UPPER, hi_w);
      set_register(alps_pkg::REG_WRAP, $urandom);
      case (phase % 4)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 70;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 70;
        end
        default: begin
          idle_pct = 38;
          stall_pct = 38;
        end
      endcase
      // long result hold-off while ticks keep coming, so the input backs up
      if (phase == 0) hold_seq++;
      phase_stop = ticks_sent + PHASE_TICKS;
      while (ticks_sent < phase_stop && ticks_sent < TICK_TOTAL) begin
        if ($urandom_range(3) != 0) begin
          case ($urandom_range(9))
            6, 7: goal = $urandom;
            8: goal = cfg_lo[31:0];
            9: goal = cfg_hi[31:0];
            default: begin
              offs = $urandom;
              goal = track_pos[31:0] + (offs >>> $urandom_range(31, 4));
            end
          endcase
          reps = $urandom_range(40, 1);
          repeat (reps) offer_target(goal, 1'b0, '0);
        end else begin
          case ($urandom_range(3))
            0: goal = 32'h7FFF_FFFF;
            1: goal = 32'h8000_0000;
            default: goal = $urandom;
          endcase
          offer_target(goal, 1'b0, '0);
        end
      end
      phase++;
    end

    drain_results();
    repeat (64) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
